// File: rtl/core/pwc_pkg.sv
// Package for the power window controller: mode codes, motor codes,
// register indexes, reset values and the structs shared by the core files.
// No dependencies.
package pwc_pkg;

    // controller modes, as reported on mode_now
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HOLD   = 3'd1,
        MODE_AUTO   = 3'd2,
        MODE_MANUAL = 3'd3,
        MODE_JAM    = 3'd4,
        MODE_GUARD  = 3'd5
    } mode_t;

    // motor commands
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_UP   = 2'd1;
    localparam logic [1:0] MOTOR_DOWN = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 16;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JAM_REVERSE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOCK_GUARD_TICKS  = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_WIDTH-1:0] HOLD_TICKS_RST        = 16'd1000;
    localparam logic [CFG_DATA_WIDTH-1:0] JAM_REVERSE_TICKS_RST = 16'd500;
    localparam logic [CFG_DATA_WIDTH-1:0] LOCK_GUARD_TICKS_RST  = 16'd100;

    // requester codes
    localparam logic REQ_DRIVER    = 1'b0;
    localparam logic REQ_PASSENGER = 1'b1;

    // beat widths
    localparam int unsigned IN_DATA_WIDTH  = 8;
    localparam int unsigned OUT_DATA_WIDTH = 8;

    // one input sample, declared msb first so it overlays s_tdata
    typedef struct packed {
        logic bottom_limit;
        logic top_limit;
        logic jam_sensor;
        logic lock_button;
        logic passenger_down;
        logic passenger_up;
        logic driver_down;
        logic driver_up;
    } pwc_sample_t;

    // one result, declared msb first so it overlays m_tdata[6:0]
    typedef struct packed {
        logic       jam_event;
        mode_t      mode_now;
        logic       window_locked;
        logic [1:0] motor_drive;
    } pwc_result_t;

    // control state apart from the countdown
    typedef struct packed {
        mode_t mode;
        logic  requester;
        logic  going_up;
        logic  lock_flag;
        logic  lock_seen;
    } pwc_state_t;

    // timing registers
    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] hold_ticks;
        logic [CFG_DATA_WIDTH-1:0] jam_reverse_ticks;
        logic [CFG_DATA_WIDTH-1:0] lock_guard_ticks;
    } pwc_cfg_t;

endpackage

// File: rtl/core/pwc_cfg_regs.sv
// Timing register file of the power window controller.
// Depends on pwc_pkg for register indexes, reset values and pwc_cfg_t.
module pwc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pwc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pwc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wr_data,
    output pwc_pkg::pwc_cfg_t                    cfg
);

    pwc_pkg::pwc_cfg_t cfg_reg;

    // write decode, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks        <= pwc_pkg::HOLD_TICKS_RST;
            cfg_reg.jam_reverse_ticks <= pwc_pkg::JAM_REVERSE_TICKS_RST;
            cfg_reg.lock_guard_ticks  <= pwc_pkg::LOCK_GUARD_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pwc_pkg::REG_HOLD_TICKS:        cfg_reg.hold_ticks        <= cfg_wr_data;
                pwc_pkg::REG_JAM_REVERSE_TICKS: cfg_reg.jam_reverse_ticks <= cfg_wr_data;
                pwc_pkg::REG_LOCK_GUARD_TICKS:  cfg_reg.lock_guard_ticks  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/pwc_fsm.sv
// Per-tick transition of the power window controller: next state, next
// countdown and the result beat. Depends on pwc_pkg for types and codes.
module pwc_fsm #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  pwc_pkg::pwc_sample_t   sample,
    input  pwc_pkg::pwc_state_t    state,
    input  logic [COUNT_WIDTH-1:0] countdown,
    input  pwc_pkg::pwc_cfg_t      cfg,
    output pwc_pkg::pwc_state_t    state_next,
    output logic [COUNT_WIDTH-1:0] countdown_next,
    output pwc_pkg::pwc_result_t   result
);

    logic [31:0]            hold_wide;
    logic [31:0]            jam_wide;
    logic [31:0]            guard_wide;
    logic [COUNT_WIDTH-1:0] hold_load;
    logic [COUNT_WIDTH-1:0] jam_load;
    logic [COUNT_WIDTH-1:0] guard_load;
    logic                   cd_done;
    logic [COUNT_WIDTH-1:0] cd_dec;
    logic                   seen;
    logic                   is_auto;
    logic                   held;
    logic                   stop;
    logic                   jam;
    logic                   jev;
    logic [1:0]             motor;

    // timer loads, registers fitted to the countdown width
    assign hold_wide  = {16'd0, cfg.hold_ticks};
    assign jam_wide   = {16'd0, cfg.jam_reverse_ticks};
    assign guard_wide = {16'd0, cfg.lock_guard_ticks};
    assign hold_load  = hold_wide[COUNT_WIDTH-1:0];
    assign jam_load   = jam_wide[COUNT_WIDTH-1:0];
    assign guard_load = guard_wide[COUNT_WIDTH-1:0];

    // countdown at one or zero ends a timed mode
    assign cd_done = (countdown[COUNT_WIDTH-1:1] == '0);
    assign cd_dec  = countdown - COUNT_WIDTH'(1);

    // lock press counted once until released
    assign seen = sample.lock_button ? state.lock_seen : 1'b0;

    // mode transition
    always_comb begin
        state_next           = state;
        state_next.lock_seen = seen;
        countdown_next       = countdown;
        is_auto              = (state.mode == pwc_pkg::MODE_AUTO);
        held                 = 1'b0;
        stop                 = 1'b0;
        jam                  = 1'b0;
        jev                  = 1'b0;
        unique case (state.mode)
            pwc_pkg::MODE_HOLD: begin
                if (cd_done) begin
                    if (state.requester == pwc_pkg::REQ_PASSENGER) begin
                        held = state.going_up ? sample.passenger_up : sample.passenger_down;
                    end else begin
                        held = state.going_up ? sample.driver_up : sample.driver_down;
                    end
                    state_next.mode = held ? pwc_pkg::MODE_MANUAL : pwc_pkg::MODE_AUTO;
                    countdown_next  = '0;
                end else begin
                    countdown_next = cd_dec;
                end
            end
            pwc_pkg::MODE_AUTO, pwc_pkg::MODE_MANUAL: begin
                jam = state.going_up && is_auto && sample.jam_sensor;
                if (state.requester == pwc_pkg::REQ_DRIVER) begin
                    if (state.going_up) begin
                        stop = sample.jam_sensor || sample.top_limit || sample.driver_down
                            || (!is_auto && !sample.driver_up);
                    end else begin
                        stop = sample.bottom_limit
                            || (is_auto ? sample.driver_up : !sample.driver_down);
                    end
                end else begin
                    if (state.going_up) begin
                        stop = sample.jam_sensor || sample.top_limit || sample.driver_up
                            || sample.driver_down || sample.lock_button
                            || (is_auto ? sample.passenger_down : !sample.passenger_up);
                    end else begin
                        stop = sample.bottom_limit || sample.driver_up || sample.driver_down
                            || sample.lock_button
                            || (is_auto ? sample.passenger_up : !sample.passenger_down);
                    end
                    // a lock press during passenger motion toggles the lock
                    if (sample.lock_button && !seen) begin
                        state_next.lock_flag = !state.lock_flag;
                        state_next.lock_seen = 1'b1;
                    end
                end
                if (jam) begin
                    state_next.mode = pwc_pkg::MODE_JAM;
                    countdown_next  = jam_load;
                    jev             = 1'b1;
                end else if (stop) begin
                    state_next.mode = pwc_pkg::MODE_IDLE;
                end
            end
            pwc_pkg::MODE_JAM, pwc_pkg::MODE_GUARD: begin
                if (cd_done) begin
                    countdown_next  = '0;
                    state_next.mode = pwc_pkg::MODE_IDLE;
                end else begin
                    countdown_next = cd_dec;
                end
            end
            default: begin
                // idle: serve presses by priority
                state_next.mode = pwc_pkg::MODE_IDLE;
                priority if (sample.driver_up) begin
                    state_next.requester = pwc_pkg::REQ_DRIVER;
                    state_next.going_up  = 1'b1;
                    state_next.mode      = pwc_pkg::MODE_HOLD;
                    countdown_next       = hold_load;
                end else if (sample.driver_down) begin
                    state_next.requester = pwc_pkg::REQ_DRIVER;
                    state_next.going_up  = 1'b0;
                    state_next.mode      = pwc_pkg::MODE_HOLD;
                    countdown_next       = hold_load;
                end else if (sample.passenger_up && !state.lock_flag) begin
                    state_next.requester = pwc_pkg::REQ_PASSENGER;
                    state_next.going_up  = 1'b1;
                    state_next.mode      = pwc_pkg::MODE_HOLD;
                    countdown_next       = hold_load;
                end else if (sample.passenger_down && !state.lock_flag) begin
                    state_next.requester = pwc_pkg::REQ_PASSENGER;
                    state_next.going_up  = 1'b0;
                    state_next.mode      = pwc_pkg::MODE_HOLD;
                    countdown_next       = hold_load;
                end else if (sample.lock_button && !seen) begin
                    state_next.lock_flag = !state.lock_flag;
                    state_next.lock_seen = 1'b1;
                    state_next.mode      = pwc_pkg::MODE_GUARD;
                    countdown_next       = guard_load;
                end else begin
                end
            end
        endcase
    end

    // motor follows the new mode
    always_comb begin
        if (state_next.mode == pwc_pkg::MODE_AUTO || state_next.mode == pwc_pkg::MODE_MANUAL) begin
            motor = state_next.going_up ? pwc_pkg::MOTOR_UP : pwc_pkg::MOTOR_DOWN;
        end else if (state_next.mode == pwc_pkg::MODE_JAM) begin
            motor = pwc_pkg::MOTOR_DOWN;
        end else begin
            motor = pwc_pkg::MOTOR_STOP;
        end
    end

    assign result.motor_drive   = motor;
    assign result.window_locked = state_next.lock_flag;
    assign result.mode_now      = state_next.mode;
    assign result.jam_event     = jev;

endmodule

// File: rtl/core/power_window_controller.sv
// Top level of the power window controller: input register, transition
// logic, state registers and output register. Depends on pwc_pkg,
// pwc_cfg_regs and pwc_fsm.
//
//  channel   direction  bus                       beat
//  s_        in         s_tvalid/s_tready/s_tdata one switch and sensor sample
//  m_        out        m_tvalid/m_tready/m_tdata one motor and status result
//  cfg_      in         cfg_wr_en/index/wr_data   one timing register write
//
// One sample per clock sustained while the m_ side keeps taking results; a taken
// beat passes the input register, then the state update into the output register.
// The whole tick update is one pass of pwc_fsm between those two registers.
// Reset clears the stages and the state and loads the timing defaults.
// A stalled m_ side holds its result while one more sample waits in the
// input register; s_tready drops only when both are full.
module power_window_controller #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample beat
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0: driver_up, driver_down, passenger_up, passenger_down,
    // lock_button, jam_sensor, top_limit, bottom_limit
    input  logic [pwc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
    // result beat
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata from bit 0: motor_drive[1:0], window_locked, mode_now[2:0],
    // jam_event, one zero pad bit
    output logic [pwc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
    // timing register writes
    input  logic                                 cfg_wr_en,
    input  logic [pwc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pwc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wr_data
);

    pwc_pkg::pwc_cfg_t     cfg;
    logic                  in_valid_reg;
    pwc_pkg::pwc_sample_t  in_data_reg;
    logic                  out_valid_reg;
    pwc_pkg::pwc_result_t  out_data_reg;
    pwc_pkg::pwc_state_t   state_reg;
    pwc_pkg::pwc_state_t   state_next;
    logic [COUNT_WIDTH-1:0] countdown_reg;
    logic [COUNT_WIDTH-1:0] countdown_next;
    pwc_pkg::pwc_result_t  result;
    logic                  advance;
    logic                  s_accept;

    pwc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pwc_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .sample         (in_data_reg),
        .state          (state_reg),
        .countdown      (countdown_reg),
        .cfg            (cfg),
        .state_next     (state_next),
        .countdown_next (countdown_next),
        .result         (result)
    );

    // handshakes
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= pwc_pkg::pwc_sample_t'(s_tdata);
        end
    end

    // controller state, stepped once per sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode      <= pwc_pkg::MODE_IDLE;
            state_reg.requester <= pwc_pkg::REQ_DRIVER;
            state_reg.going_up  <= 1'b0;
            state_reg.lock_flag <= 1'b0;
            state_reg.lock_seen <= 1'b0;
            countdown_reg       <= '0;
        end else if (advance) begin
            state_reg     <= state_next;
            countdown_reg <= countdown_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

// File: rtl/core/pwc_checker.sv
// Port-level checks for the power window controller, bound to the top level.
// Depends on pwc_pkg for mode and motor codes.
module pwc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pwc_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

    logic [1:0] motor;
    logic [2:0] mode;
    logic       jev;

    assign motor = m_tdata[1:0];
    assign mode  = m_tdata[5:3];
    assign jev   = m_tdata[6];

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // input side stalls only when a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("sample side stalled with no waiting result");

    // a jam beat reports jam reverse with the motor going down
    a_jam_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && jev |-> mode == 3'(pwc_pkg::MODE_JAM) && motor == pwc_pkg::MOTOR_DOWN)
        else $error("jam event without reverse drive");

    // motor is stopped in idle, hold timing and lock guard
    a_motor_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (mode == 3'(pwc_pkg::MODE_IDLE) || mode == 3'(pwc_pkg::MODE_HOLD)
            || mode == 3'(pwc_pkg::MODE_GUARD)) |-> motor == pwc_pkg::MOTOR_STOP)
        else $error("motor driven in a resting mode");

endmodule

bind power_window_controller pwc_checker u_pwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
